### src/assert_macros.svh
// Assertion helpers used by space_time_histogram_binner.
// Define ASSERT_OFF to compile every check away.
`ifndef ASSERT_MACROS_SVH
`define ASSERT_MACROS_SVH
`ifndef ASSERT_OFF
// Same-cycle implication, disabled while reset is high
`define ASSERT_IMPLY(label, clk, rst, ante, cons, msg) \
   label: assert property (@(posedge clk) disable iff (rst) (ante) |-> (cons)) \
      else $error(msg);
// Next-cycle implication, disabled while reset is high
`define ASSERT_NEXT(label, clk, rst, ante, cons, msg) \
   label: assert property (@(posedge clk) disable iff (rst) (ante) |=> (cons)) \
      else $error(msg);
`else
`define ASSERT_IMPLY(label, clk, rst, ante, cons, msg)
`define ASSERT_NEXT(label, clk, rst, ante, cons, msg)
`endif
`endif

### src/sthb_pkg.sv
package sthb_pkg;

   // Histogram geometry
   localparam int DIMS          = 3;
   localparam int BINS_PER_DIM  = 8;
   localparam int SPECIES_COUNT = 4;
   localparam int SLICE_BINS    = 32;
   localparam int BIN_W         = $clog2(BINS_PER_DIM);

   // Bin store
   localparam int STORE_DEPTH = 65536;
   localparam int ADDR_W      = 16;
   localparam int COUNT_W     = 16;

   // Field widths
   localparam int POS_W   = 20;
   localparam int INV_W   = 20;
   localparam int SLICE_W = 11;
   localparam int PROD_W  = 42;
   localparam int FRAC2_W = 24;
   localparam int AXIS_W  = 2;

   // Serial divider
   localparam int DIV_W     = 11;
   localparam int DIV_CNT_W = $clog2(DIV_W + 1);

   // Command codes
   localparam logic [1:0] CMD_ADD   = 2'd0;
   localparam logic [1:0] CMD_READ  = 2'd1;
   localparam logic [1:0] CMD_CLEAR = 2'd2;

   // Configuration register indexes
   localparam int CSR_IDX_W = 3;
   localparam int CSR_DATA_W = 20;
   localparam logic [CSR_IDX_W-1:0] CSR_ORIGIN_X    = 3'd0;
   localparam logic [CSR_IDX_W-1:0] CSR_ORIGIN_Y    = 3'd1;
   localparam logic [CSR_IDX_W-1:0] CSR_ORIGIN_Z    = 3'd2;
   localparam logic [CSR_IDX_W-1:0] CSR_INV_BIN_X   = 3'd3;
   localparam logic [CSR_IDX_W-1:0] CSR_INV_BIN_Y   = 3'd4;
   localparam logic [CSR_IDX_W-1:0] CSR_INV_BIN_Z   = 3'd5;
   localparam logic [CSR_IDX_W-1:0] CSR_SLICE_STRIDE = 3'd6;
   localparam logic [CSR_IDX_W-1:0] CSR_SLICE_TOTAL  = 3'd7;

   typedef struct packed {
      logic [1:0]              cmd;
      logic signed [POS_W-1:0] pos_x;
      logic signed [POS_W-1:0] pos_y;
      logic signed [POS_W-1:0] pos_z;
      logic [1:0]              species;
      logic [9:0]              slice_index;
      logic [15:0]             read_index;
   } req_type;

   typedef struct packed {
      logic [COUNT_W-1:0] count;
      logic               counted;
   } rsp_type;

   typedef struct packed {
      logic             start;
      logic [DIV_W-1:0] dividend;
      logic [DIV_W-1:0] divisor;
   } div_req_type;

   typedef struct packed {
      logic             done;
      logic [DIV_W-1:0] quo;
      logic [DIV_W-1:0] rem;
   } div_rsp_type;

endpackage

### src/sthb_ram.sv
module sthb_ram #(
   parameter int WIDTH = 16,
   parameter int DEPTH = 65536
) (
   input  logic                     clock,
   input  logic                     wr_en,
   input  logic [$clog2(DEPTH)-1:0] wr_addr,
   input  logic [WIDTH-1:0]         wr_data,
   input  logic [$clog2(DEPTH)-1:0] rd_addr,
   output logic [WIDTH-1:0]         rd_data
);

   logic [WIDTH-1:0] mem_ff [DEPTH];
   logic [WIDTH-1:0] rd_data_ff;

   // One write port, one registered read port
   always_ff @(posedge clock) begin
      if (wr_en) begin
         mem_ff[wr_addr] <= wr_data;
      end
      rd_data_ff <= mem_ff[rd_addr];
   end

   assign rd_data = rd_data_ff;

endmodule

### src/sthb_div.sv
module sthb_div import sthb_pkg::*; (
   input  logic        clock,
   input  logic        reset,
   input  div_req_type div_req,
   output div_rsp_type div_rsp
);

   logic                 busy_ff, busy_in;
   logic                 done_ff, done_in;
   logic [DIV_CNT_W-1:0] cnt_ff, cnt_in;
   logic [DIV_W-1:0]     rem_ff, rem_in;
   logic [DIV_W-1:0]     quo_ff, quo_in;
   logic [DIV_W-1:0]     dsr_ff, dsr_in;
   logic [DIV_W:0]       shifted;
   logic [DIV_W:0]       diff;

   // One restoring step: shift in the next dividend bit, subtract if it fits
   always_comb begin
      shifted = {rem_ff, quo_ff[DIV_W-1]};
      diff    = shifted - {1'b0, dsr_ff};
      busy_in = busy_ff;
      done_in = 1'b0;
      cnt_in  = cnt_ff;
      rem_in  = rem_ff;
      quo_in  = quo_ff;
      dsr_in  = dsr_ff;
      if (div_req.start) begin
         busy_in = 1'b1;
         cnt_in  = DIV_CNT_W'(DIV_W);
         rem_in  = '0;
         quo_in  = div_req.dividend;
         dsr_in  = div_req.divisor;
      end else if (busy_ff) begin
         if (!diff[DIV_W]) begin
            rem_in = diff[DIV_W-1:0];
            quo_in = {quo_ff[DIV_W-2:0], 1'b1};
         end else begin
            rem_in = shifted[DIV_W-1:0];
            quo_in = {quo_ff[DIV_W-2:0], 1'b0};
         end
         cnt_in = cnt_ff - 1'b1;
         if (cnt_ff == DIV_CNT_W'(1)) begin
            busy_in = 1'b0;
            done_in = 1'b1;
         end
      end
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         busy_ff <= 1'b0;
         done_ff <= 1'b0;
      end else begin
         busy_ff <= busy_in;
         done_ff <= done_in;
      end
   end

   always_ff @(posedge clock) begin
      cnt_ff <= cnt_in;
      rem_ff <= rem_in;
      quo_ff <= quo_in;
      dsr_ff <= dsr_in;
   end

   assign div_rsp.done = done_ff;
   assign div_rsp.quo  = quo_ff;
   assign div_rsp.rem  = rem_ff;

endmodule

### src/space_time_histogram_binner.sv
// Add: up to three passes through the shared 11-bit serial divider, then one
// multiply and one range check per axis, then a bin read and update; a failed
// check ends it early. Read: a bin store read. Clear: a sweep of the store.
// One item at a time; the next item is taken once the result is registered.
// Reset is synchronous; after reset a sweep zeroes every entry of the bin store
// and no item is accepted until it ends. Configuration returns to defaults.
`include "assert_macros.svh"

module space_time_histogram_binner import sthb_pkg::*; (
   input  logic                  clock,
   input  logic                  reset,
   input  logic                  req_valid,
   output logic                  req_stall,
   input  req_type               req_data,
   output logic                  rsp_valid,
   input  logic                  rsp_stall,
   output rsp_type               rsp_data,
   input  logic                  csr_we,
   input  logic [CSR_IDX_W-1:0]  csr_index,
   input  logic [CSR_DATA_W-1:0] csr_wdata
);

   typedef enum logic [3:0] {
      ST_IDLE, ST_CLR, ST_DIV_N, ST_DIV_Q, ST_DIV_S,
      ST_MUL, ST_CHK, ST_RD, ST_UPD, ST_FIN
   } state_type;

   // Configuration registers
   logic signed [POS_W-1:0] origin_x_ff, origin_y_ff, origin_z_ff;
   logic [INV_W-1:0]        inv_bin_x_ff, inv_bin_y_ff, inv_bin_z_ff;
   logic [SLICE_W-1:0]      stride_ff, total_ff;

   // Sequencer state
   state_type           state_ff, state_in;
   logic [ADDR_W-1:0]   sweep_ff, sweep_in;
   logic                clr_cmd_ff, clr_cmd_in;
   logic                rsp_valid_ff, rsp_valid_in;
   rsp_type             rsp_data_ff, rsp_data_in;
   div_req_type         div_req_ff, div_req_in;
   div_rsp_type         div_rsp;

   // Item working registers
   req_type             item_ff, item_in;
   logic                ok_ff, ok_in;
   logic                is_add_ff, is_add_in;
   logic [DIV_W-1:0]    neff_ff, neff_in;
   logic [DIV_W-1:0]    sbin_ff, sbin_in;
   logic [AXIS_W-1:0]   axis_ff, axis_in;
   logic [ADDR_W-1:0]   addr_ff, addr_in;
   logic signed [PROD_W-1:0] prod_ff, prod_in;
   rsp_type             res_ff, res_in;

   // Datapath signals
   logic [SLICE_W-1:0]      stride_eff;
   logic signed [POS_W-1:0] axis_pos, axis_org;
   logic [INV_W-1:0]        axis_inv;
   logic signed [POS_W:0]   diff_s;
   logic signed [POS_W:0]   inv_s;
   logic [ADDR_W-1:0]       addr_next;
   logic [BIN_W-1:0]        bin;
   logic                    ram_we;
   logic [ADDR_W-1:0]       ram_waddr;
   logic [COUNT_W-1:0]      ram_wdata;
   logic [COUNT_W-1:0]      ram_rdata;
   logic [COUNT_W-1:0]      cnt_new;

   // Configuration writes
   always_ff @(posedge clock) begin
      if (reset) begin
         origin_x_ff  <= '0;
         origin_y_ff  <= '0;
         origin_z_ff  <= '0;
         inv_bin_x_ff <= INV_W'(4096);
         inv_bin_y_ff <= INV_W'(4096);
         inv_bin_z_ff <= INV_W'(4096);
         stride_ff    <= SLICE_W'(1);
         total_ff     <= SLICE_W'(32);
      end else if (csr_we) begin
         unique case (csr_index)
            CSR_ORIGIN_X:     origin_x_ff  <= csr_wdata;
            CSR_ORIGIN_Y:     origin_y_ff  <= csr_wdata;
            CSR_ORIGIN_Z:     origin_z_ff  <= csr_wdata;
            CSR_INV_BIN_X:    inv_bin_x_ff <= csr_wdata;
            CSR_INV_BIN_Y:    inv_bin_y_ff <= csr_wdata;
            CSR_INV_BIN_Z:    inv_bin_z_ff <= csr_wdata;
            CSR_SLICE_STRIDE: stride_ff    <= csr_wdata[SLICE_W-1:0];
            CSR_SLICE_TOTAL:  total_ff     <= csr_wdata[SLICE_W-1:0];
            default: ;
         endcase
      end
   end

   // A zero stride counts as one
   assign stride_eff = (stride_ff == '0) ? SLICE_W'(1) : stride_ff;

   // Select the operands of the current axis
   always_comb begin
      unique case (axis_ff)
         2'd0: begin
            axis_pos = item_ff.pos_x;
            axis_org = origin_x_ff;
            axis_inv = inv_bin_x_ff;
         end
         2'd1: begin
            axis_pos = item_ff.pos_y;
            axis_org = origin_y_ff;
            axis_inv = inv_bin_y_ff;
         end
         default: begin
            axis_pos = item_ff.pos_z;
            axis_org = origin_z_ff;
            axis_inv = inv_bin_z_ff;
         end
      endcase
      diff_s = {axis_pos[POS_W-1], axis_pos} - {axis_org[POS_W-1], axis_org};
      inv_s  = {1'b0, axis_inv};
   end

   assign bin       = prod_ff[FRAC2_W +: BIN_W];
   assign addr_next = ADDR_W'(32'(addr_ff) * BINS_PER_DIM + 32'(bin));
   assign cnt_new   = (ram_rdata == '1) ? ram_rdata : ram_rdata + 1'b1;

   // Sequencer
   always_comb begin
      state_in     = state_ff;
      sweep_in     = sweep_ff;
      clr_cmd_in   = clr_cmd_ff;
      rsp_valid_in = rsp_valid_ff & rsp_stall;
      rsp_data_in  = rsp_data_ff;
      div_req_in   = div_req_ff;
      div_req_in.start = 1'b0;
      item_in      = item_ff;
      ok_in        = ok_ff;
      is_add_in    = is_add_ff;
      neff_in      = neff_ff;
      sbin_in      = sbin_ff;
      axis_in      = axis_ff;
      addr_in      = addr_ff;
      prod_in      = prod_ff;
      res_in       = res_ff;
      ram_we       = 1'b0;
      ram_waddr    = addr_ff;
      ram_wdata    = cnt_new;

      unique case (state_ff)
         ST_IDLE: begin
            if (req_valid) begin
               item_in = req_data;
               res_in  = '0;
               unique case (req_data.cmd)
                  CMD_ADD: begin
                     ok_in = 32'(req_data.species) < SPECIES_COUNT;
                     div_req_in.start    = 1'b1;
                     div_req_in.dividend = total_ff;
                     div_req_in.divisor  = stride_eff;
                     state_in = ST_DIV_N;
                  end
                  CMD_READ: begin
                     addr_in   = req_data.read_index;
                     is_add_in = 1'b0;
                     state_in  = ST_RD;
                  end
                  CMD_CLEAR: begin
                     sweep_in   = '0;
                     clr_cmd_in = 1'b1;
                     state_in   = ST_CLR;
                  end
                  default: state_in = ST_FIN;
               endcase
            end
         end
         ST_CLR: begin
            // Zero one entry per cycle
            ram_we    = 1'b1;
            ram_waddr = sweep_ff;
            ram_wdata = '0;
            sweep_in  = sweep_ff + 1'b1;
            if (sweep_ff == '1) begin
               res_in   = '0;
               state_in = clr_cmd_ff ? ST_FIN : ST_IDLE;
            end
         end
         ST_DIV_N: begin
            // Number of usable slice bins
            if (div_rsp.done) begin
               neff_in = div_rsp.quo;
               if (div_rsp.quo == '0) begin
                  ok_in = 1'b0;
               end
               div_req_in.start    = 1'b1;
               div_req_in.dividend = DIV_W'(item_ff.slice_index);
               div_req_in.divisor  = stride_eff;
               state_in = ST_DIV_Q;
            end
         end
         ST_DIV_Q: begin
            // Drop slices off the stride, then wrap by the bin count
            if (div_rsp.done) begin
               if (!ok_ff || div_rsp.rem != '0) begin
                  res_in   = '0;
                  state_in = ST_FIN;
               end else begin
                  div_req_in.start    = 1'b1;
                  div_req_in.dividend = div_rsp.quo;
                  div_req_in.divisor  = neff_ff;
                  state_in = ST_DIV_S;
               end
            end
         end
         ST_DIV_S: begin
            if (div_rsp.done) begin
               sbin_in = div_rsp.rem;
               if (32'(div_rsp.rem) >= SLICE_BINS) begin
                  res_in   = '0;
                  state_in = ST_FIN;
               end else begin
                  axis_in  = '0;
                  addr_in  = ADDR_W'(item_ff.species);
                  state_in = ST_MUL;
               end
            end
         end
         ST_MUL: begin
            prod_in  = diff_s * inv_s;
            state_in = ST_CHK;
         end
         ST_CHK: begin
            // Negative or past the last bin drops the sample
            if (prod_ff[PROD_W-1] ||
                32'(prod_ff[PROD_W-1:FRAC2_W]) >= BINS_PER_DIM) begin
               res_in   = '0;
               state_in = ST_FIN;
            end else if (32'(axis_ff) == DIMS - 1) begin
               addr_in   = ADDR_W'(32'(addr_next) * SLICE_BINS + 32'(sbin_ff));
               is_add_in = 1'b1;
               state_in  = ST_RD;
            end else begin
               addr_in  = addr_next;
               axis_in  = axis_ff + 1'b1;
               state_in = ST_MUL;
            end
         end
         ST_RD: begin
            state_in = ST_UPD;
         end
         ST_UPD: begin
            if (is_add_ff) begin
               ram_we = 1'b1;
               res_in = '{count: cnt_new, counted: 1'b1};
            end else begin
               res_in = '{count: ram_rdata, counted: 1'b0};
            end
            state_in = ST_FIN;
         end
         ST_FIN: begin
            // Hold until the output register is free
            if (!rsp_valid_ff || !rsp_stall) begin
               rsp_valid_in = 1'b1;
               rsp_data_in  = res_ff;
               state_in     = ST_IDLE;
            end
         end
         default: state_in = ST_IDLE;
      endcase
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         state_ff     <= ST_CLR;
         sweep_ff     <= '0;
         clr_cmd_ff   <= 1'b0;
         rsp_valid_ff <= 1'b0;
         div_req_ff   <= '0;
      end else begin
         state_ff     <= state_in;
         sweep_ff     <= sweep_in;
         clr_cmd_ff   <= clr_cmd_in;
         rsp_valid_ff <= rsp_valid_in;
         div_req_ff   <= div_req_in;
      end
   end

   always_ff @(posedge clock) begin
      rsp_data_ff <= rsp_data_in;
      item_ff     <= item_in;
      ok_ff       <= ok_in;
      is_add_ff   <= is_add_in;
      neff_ff     <= neff_in;
      sbin_ff     <= sbin_in;
      axis_ff     <= axis_in;
      addr_ff     <= addr_in;
      prod_ff     <= prod_in;
      res_ff      <= res_in;
   end

   sthb_div u_div (
      .clock   (clock),
      .reset   (reset),
      .div_req (div_req_ff),
      .div_rsp (div_rsp)
   );

   sthb_ram #(
      .WIDTH (COUNT_W),
      .DEPTH (STORE_DEPTH)
   ) u_bins (
      .clock   (clock),
      .wr_en   (ram_we),
      .wr_addr (ram_waddr),
      .wr_data (ram_wdata),
      .rd_addr (addr_ff),
      .rd_data (ram_rdata)
   );

   assign req_stall = (state_ff != ST_IDLE);
   assign rsp_valid = rsp_valid_ff;
   assign rsp_data  = rsp_data_ff;

   `ASSERT_IMPLY(a_counted_nonzero, clock, reset, rsp_valid && rsp_data.counted, rsp_data.count != '0, "counted beat with zero count")
   `ASSERT_NEXT(a_clear_sweeps, clock, reset, req_valid && !req_stall && req_data.cmd == CMD_CLEAR, state_ff == ST_CLR && sweep_ff == '0, "clear did not start sweep")
   `ASSERT_IMPLY(a_ram_write_state, clock, reset, ram_we, state_ff == ST_CLR || state_ff == ST_UPD, "bin store written outside sweep or update")
   `ASSERT_NEXT(a_fin_holds, clock, reset, state_ff == ST_FIN && rsp_valid_ff && rsp_stall, state_ff == ST_FIN, "result dropped while output busy")

endmodule
